// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the address-resolution cache engine.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ST_DISABLED = 2'd0;
    localparam logic [1:0] ST_WAITING  = 2'd1;
    localparam logic [1:0] ST_ENABLED  = 2'd2;

    localparam logic [1:0] CMD_RESOLVE = 2'd0;
    localparam logic [1:0] CMD_LEARN   = 2'd1;
    localparam logic [1:0] CMD_ARP     = 2'd2;

    localparam logic [2:0] STS_UPDATED = 3'd0;
    localparam logic [2:0] STS_IGNORED = 3'd1;
    localparam logic [2:0] STS_FULL    = 3'd2;
    localparam logic [2:0] STS_HIT     = 3'd3;
    localparam logic [2:0] STS_QUERY   = 3'd4;
    localparam logic [2:0] STS_BCAST   = 3'd5;

    localparam logic [15:0] OPER_REQUEST = 16'd1;
    localparam logic [15:0] OPER_REPLY   = 16'd2;

    localparam logic [9:0]  LIFE_RELOAD = 10'd600;
    localparam logic [31:0] IP_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  FRAG_KEEP   = 2'b11;

    localparam logic [1:0] CFG_LOCAL_IP   = 2'd0;
    localparam logic [1:0] CFG_GATEWAY_IP = 2'd1;
    localparam logic [1:0] CFG_NET_MASK   = 2'd2;
    localparam logic [1:0] CFG_LOCAL_MAC  = 2'd3;

    localparam logic [IDX_W-1:0] IDX_NONE = IDX_W'(ENTRIES);

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [15:0] frag_field;
        logic [15:0] arp_oper;
        logic [31:0] target_ip;
        logic [47:0] target_mac;
    } arpc_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [47:0] mac_out;
        logic [31:0] query_ip;
        logic        reply_needed;
        logic        via_gateway;
    } arpc_rsp_t;

    typedef struct packed {
        logic [31:0]      key;
        logic             any_found;
        logic [IDX_W-1:0] any_idx;
        logic [1:0]       any_state;
        logic             en_found;
        logic [IDX_W-1:0] en_idx;
        logic [47:0]      en_mac;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } arpc_probe_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             set_state;
        logic [1:0]       state;
        logic             set_ip;
        logic [31:0]      ip;
        logic             set_mac;
        logic [47:0]      mac;
        logic             set_life;
    } arpc_wr_t;

endpackage

`default_nettype wire

// ===== sv/arpc_cell.sv =====
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry; updates the passing probe and forwards it each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell
    import arpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_id,
    input  wire arpc_probe_t      probe_prev,
    output arpc_probe_t           probe,
    input  wire arpc_wr_t         wr
);

    logic [1:0]  state_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [9:0]  life_reg;
    arpc_probe_t probe_reg;
    arpc_probe_t probe_next;
    logic        match;
    logic        sel;

    assign match = (ip_reg == probe_prev.key);
    assign sel   = wr.en && (wr.idx == cell_id);

    always_comb
    begin
        probe_next = probe_prev;
        if (!probe_prev.any_found && match)
        begin
            probe_next.any_found = 1'b1;
            probe_next.any_idx   = cell_id;
            probe_next.any_state = state_reg;
        end
        if (!probe_prev.en_found && match && state_reg == ST_ENABLED)
        begin
            probe_next.en_found = 1'b1;
            probe_next.en_idx   = cell_id;
            probe_next.en_mac   = mac_reg;
        end
        if (!probe_prev.free_found && state_reg == ST_DISABLED)
        begin
            probe_next.free_found = 1'b1;
            probe_next.free_idx   = cell_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DISABLED;
            ip_reg    <= '0;
            mac_reg   <= '0;
            life_reg  <= '0;
        end
        else if (sel)
        begin
            if (wr.set_state)
                state_reg <= wr.state;
            if (wr.set_ip)
                ip_reg <= wr.ip;
            if (wr.set_mac)
                mac_reg <= wr.mac;
            if (wr.set_life)
                life_reg <= LIFE_RELOAD;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
    end

    assign probe = probe_reg;

    a_life_values: assert property (@(posedge clk) disable iff (!rst_n)
        (life_reg == 10'd0) || (life_reg == LIFE_RELOAD))
        else $error("lifetime holds an unexpected value");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        sel && wr.set_state |=> (state_reg == ST_WAITING) || (state_reg == ST_ENABLED))
        else $error("entry written with a disabled state");

endmodule

`default_nettype wire

// ===== sv/arp_cache_engine_top.sv =====
// ----------------------------------------------------------------------------
// arp_cache_engine_top
// Address-resolution cache: resolve, learn and ARP handling over a cell chain.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  arpc_req_t
// rsp      out        rsp_valid/rsp_stall  arpc_rsp_t
// cfg      in         cfg_we               cfg_index, cfg_data
//
// An item passes through S_SEARCH, where the probe walks the cell chain
// one cell register at a time, S_DECIDE, which decides and writes, and
// S_OUT, which presents the result until it leaves. The next item is
// taken in S_IDLE, after the result leaves.
// One item is in flight at a time; req_stall is high while it is worked on.
// A result holds on rsp until rsp_stall is low.
// Reset disables all entries and clears the state, counter and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_engine_top
    import arpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire arpc_req_t   req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output arpc_rsp_t        rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      local_ip_reg, gateway_ip_reg, net_mask_reg;
    logic [47:0]      local_mac_reg;
    arpc_req_t        req_reg;
    logic [31:0]      key_reg;
    logic             via_reg;
    arpc_rsp_t        rsp_reg, rsp_next;
    arpc_wr_t         wr;
    arpc_probe_t      chain [ENTRIES+1];
    arpc_probe_t      res;
    logic             via_now;
    logic             learn_sel_found;
    logic [IDX_W-1:0] learn_sel_idx;

    assign via_now = (req.ip_addr & net_mask_reg) != (local_ip_reg & net_mask_reg);

    always_comb
    begin
        chain[0]            = '0;
        chain[0].key        = key_reg;
    end

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_cell
        arpc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_id    (IDX_W'(gi)),
            .probe_prev (chain[gi]),
            .probe      (chain[gi+1]),
            .wr         (wr)
        );
    end

    assign res = chain[ENTRIES];

    always_comb
    begin
        learn_sel_found = res.free_found;
        learn_sel_idx   = res.free_idx;
        if (res.any_found && res.any_state == ST_ENABLED)
        begin
            learn_sel_found = 1'b1;
            learn_sel_idx   = res.any_idx;
        end
    end

    always_comb
    begin
        wr       = '0;
        rsp_next = '0;
        rsp_next.status      = STS_IGNORED;
        rsp_next.entry_index = IDX_NONE;
        case (req_reg.command)
            CMD_RESOLVE:
            begin
                if (req_reg.ip_addr == IP_ALL_ONES)
                begin
                    rsp_next.status  = STS_BCAST;
                    rsp_next.mac_out = MAC_ALL_ONES;
                end
                else
                begin
                    rsp_next.via_gateway = via_reg;
                    rsp_next.query_ip    = key_reg;
                    if (res.en_found)
                    begin
                        wr.idx               = res.en_idx;
                        wr.set_life          = 1'b1;
                        rsp_next.status      = STS_HIT;
                        rsp_next.entry_index = res.en_idx;
                        rsp_next.mac_out     = res.en_mac;
                    end
                    else if (res.free_found)
                    begin
                        wr.idx               = res.free_idx;
                        wr.set_state         = 1'b1;
                        wr.state             = ST_WAITING;
                        wr.set_ip            = 1'b1;
                        wr.ip                = key_reg;
                        rsp_next.status      = STS_QUERY;
                        rsp_next.entry_index = res.free_idx;
                    end
                    else
                    begin
                        rsp_next.status = STS_FULL;
                    end
                    wr.en = res.en_found || res.free_found;
                end
            end
            CMD_LEARN:
            begin
                if (req_reg.frag_field != 16'd0
                    && (req_reg.frag_field[15:14] & FRAG_KEEP) == 2'b00)
                begin
                    rsp_next.status = STS_IGNORED;
                end
                else if (learn_sel_found)
                begin
                    wr.en                = 1'b1;
                    wr.idx               = learn_sel_idx;
                    wr.set_state         = 1'b1;
                    wr.state             = ST_ENABLED;
                    wr.set_ip            = 1'b1;
                    wr.ip                = req_reg.ip_addr;
                    wr.set_mac           = 1'b1;
                    wr.mac               = req_reg.mac_addr;
                    wr.set_life          = 1'b1;
                    rsp_next.status      = STS_UPDATED;
                    rsp_next.entry_index = learn_sel_idx;
                end
                else
                begin
                    rsp_next.status = STS_FULL;
                end
            end
            CMD_ARP:
            begin
                if (req_reg.arp_oper == OPER_REQUEST && req_reg.target_ip == local_ip_reg)
                begin
                    rsp_next.reply_needed = 1'b1;
                    rsp_next.mac_out      = req_reg.mac_addr;
                    rsp_next.query_ip     = req_reg.ip_addr;
                end
                else if (req_reg.arp_oper == OPER_REPLY
                         && req_reg.target_ip == local_ip_reg
                         && req_reg.target_mac == local_mac_reg
                         && res.any_found && res.any_state == ST_WAITING)
                begin
                    wr.en                = 1'b1;
                    wr.idx               = res.any_idx;
                    wr.set_state         = 1'b1;
                    wr.state             = ST_ENABLED;
                    wr.set_mac           = 1'b1;
                    wr.mac               = req_reg.mac_addr;
                    rsp_next.status      = STS_UPDATED;
                    rsp_next.entry_index = res.any_idx;
                end
            end
            default:
            begin
                rsp_next.status = STS_IGNORED;
            end
        endcase
        if (state_reg != S_DECIDE)
            wr.en = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_valid)
                    state_next = S_SEARCH;
            S_SEARCH:
                if (cnt_reg == CNT_W'(ENTRIES - 1))
                    state_next = S_DECIDE;
            S_DECIDE:
                state_next = S_OUT;
            S_OUT:
                if (!rsp_stall)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            local_ip_reg   <= '0;
            gateway_ip_reg <= '0;
            net_mask_reg   <= '0;
            local_mac_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SEARCH)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOCAL_IP:   local_ip_reg   <= cfg_data[31:0];
                    CFG_GATEWAY_IP: gateway_ip_reg <= cfg_data[31:0];
                    CFG_NET_MASK:   net_mask_reg   <= cfg_data[31:0];
                    CFG_LOCAL_MAC:  local_mac_reg  <= cfg_data;
                    default:        local_mac_reg  <= local_mac_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
            via_reg <= via_now;
            if (req.command == CMD_RESOLVE && via_now)
                key_reg <= gateway_ip_reg;
            else
                key_reg <= req.ip_addr;
        end
        if (state_reg == S_DECIDE)
            rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    a_rsp_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == S_DECIDE)
        else $error("result raised without a decide cycle");

    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_HIT || rsp.status == STS_QUERY)
        |-> rsp.entry_index < IDX_NONE)
        else $error("hit or query result without a valid entry");

endmodule

`default_nettype wire
